// ----- hdl/ceb_pkg.sv -----
// Shared constants and types of the coincidence event builder.
package ceb_pkg;

    localparam int EVENT_DEPTH_DEF = 64;
    localparam int MAX_REQ_DEF     = 4;
    localparam int TIME_BITS_DEF   = 48;

    localparam int ADDR_W     = 32;
    localparam int REQ_ADDR_W = 17;
    localparam int REQ_SLOTS  = 4;
    localparam int DELTA_W    = 16;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [REQ_ADDR_W-1:0] PAD_ADDR      = 17'h05006;
    localparam logic [DELTA_W-1:0]    MAX_DELTA_RST = 16'd500;

    localparam logic MODE_HIT   = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ADDR_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ADDR_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ADDR_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ADDR_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 3'd6;

    typedef struct packed {
        logic [2:0]                           req_count;
        logic [REQ_SLOTS-1:0][REQ_ADDR_W-1:0] req_addr;
        logic [2:0]                           req_mode;
        logic [DELTA_W-1:0]                   max_delta;
    } cfg_t;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             accepted;
        logic             truncated;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

// ----- hdl/ceb_if.sv -----
// Handshake channels for hits in and event words out.
interface ceb_in_if #(parameter int TIME_BITS = ceb_pkg::TIME_BITS_DEF);
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [TIME_BITS-1:0]      hit_time;
    logic [ceb_pkg::ADDR_W-1:0] hit_address;
    logic                      hit_side;

    modport source (output valid, mode, hit_time, hit_address, hit_side, input ready);
    modport sink   (input valid, mode, hit_time, hit_address, hit_side, output ready);
endinterface

interface ceb_out_if #(parameter int TIME_BITS = ceb_pkg::TIME_BITS_DEF);
    logic                      valid;
    logic                      ready;
    logic [TIME_BITS-1:0]      out_time;
    logic [ceb_pkg::ADDR_W-1:0] out_address;
    logic                      out_side;
    logic                      accepted;
    logic                      last_of_event;
    logic                      truncated;

    modport source (output valid, out_time, out_address, out_side, accepted, last_of_event,
                    truncated, input ready);
    modport sink   (input valid, out_time, out_address, out_side, accepted, last_of_event,
                    truncated, output ready);
endinterface

// ----- hdl/coincidence_event_builder.sv -----
// Top level of the coincidence event builder: configuration registers and the front/back split.
//
// Hits enter through the hits channel at up to one word per cycle and are grouped
// into events of max_delta ticks from the first hit; each closed event is played out
// on the events channel at one word per cycle while the receiver is ready, every word
// carrying the accepted, last_of_event and truncated flags. Events are buffered in two
// banks of EVENT_DEPTH entries: while one bank drains, the next event fills the other.
// With the drain side idle, a closed event's first word passes from the command queue
// through the drain side's command load, the buffer read register and the output
// register; the drain side loads each event's command before reading it out, so
// back-to-back events leave a gap on the output. A hit that would open a new event
// waits while both banks are still held by events not yet drained, so sustained rate
// is one hit per cycle as long as the output side keeps up with the bank drain. Configuration
// is written through cfg_we/cfg_index/cfg_data; write it only while the block is idle.
module coincidence_event_builder #(
    parameter int EVENT_DEPTH = ceb_pkg::EVENT_DEPTH_DEF,
    parameter int MAX_REQ     = ceb_pkg::MAX_REQ_DEF,
    parameter int TIME_BITS   = ceb_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ceb_in_if.sink                            hits,
    ceb_out_if.source                         events,
    input  logic                              cfg_we,
    input  logic [ceb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ceb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int AW = $clog2(EVENT_DEPTH) + 1;

    ceb_pkg::cfg_t     cfg_reg, cfg_next;
    ceb_pkg::cmd_t     push_cmd, pop_cmd;
    ceb_pkg::release_t rel;
    logic              cmd_push, cmd_ready, cmd_pop, cmd_valid;

    logic                       wr_en, rd_en;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [TIME_BITS-1:0]       wr_time, rd_time;
    logic [ceb_pkg::ADDR_W-1:0] wr_address, rd_address;
    logic                       wr_side, rd_side;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ceb_pkg::CFG_REQ_COUNT:  cfg_next.req_count   = cfg_data[2:0];
                ceb_pkg::CFG_REQ_ADDR_0: cfg_next.req_addr[0] = cfg_data;
                ceb_pkg::CFG_REQ_ADDR_1: cfg_next.req_addr[1] = cfg_data;
                ceb_pkg::CFG_REQ_ADDR_2: cfg_next.req_addr[2] = cfg_data;
                ceb_pkg::CFG_REQ_ADDR_3: cfg_next.req_addr[3] = cfg_data;
                ceb_pkg::CFG_REQ_MODE:   cfg_next.req_mode    = cfg_data[2:0];
                ceb_pkg::CFG_MAX_DELTA:  cfg_next.max_delta   = cfg_data[ceb_pkg::DELTA_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ceb_pkg::cfg_t'{req_count: '0, req_addr: '0, req_mode: '0,
                                       max_delta: ceb_pkg::MAX_DELTA_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ceb_front #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .MAX_REQ     (MAX_REQ),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hits       (hits),
        .cfg        (cfg_reg),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .cmd_ready  (cmd_ready),
        .rel        (rel),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_time    (wr_time),
        .wr_address (wr_address),
        .wr_side    (wr_side)
    );

    ceb_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .push_ready (cmd_ready),
        .pop        (cmd_pop),
        .pop_valid  (cmd_valid),
        .pop_cmd    (pop_cmd)
    );

    ceb_buf #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_buf (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_time    (wr_time),
        .wr_address (wr_address),
        .wr_side    (wr_side),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_time    (rd_time),
        .rd_address (rd_address),
        .rd_side    (rd_side)
    );

    ceb_back #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (cmd_pop),
        .rel        (rel),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_time    (rd_time),
        .rd_address (rd_address),
        .rd_side    (rd_side),
        .events     (events)
    );

endmodule

// ----- hdl/ceb_buf.sv -----
// Two-bank hit buffer: one write port, one registered read port.
module ceb_buf #(
    parameter int EVENT_DEPTH = ceb_pkg::EVENT_DEPTH_DEF,
    parameter int TIME_BITS   = ceb_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(EVENT_DEPTH):0] wr_addr,
    input  logic [TIME_BITS-1:0]       wr_time,
    input  logic [ceb_pkg::ADDR_W-1:0] wr_address,
    input  logic                       wr_side,
    input  logic                       rd_en,
    input  logic [$clog2(EVENT_DEPTH):0] rd_addr,
    output logic [TIME_BITS-1:0]       rd_time,
    output logic [ceb_pkg::ADDR_W-1:0] rd_address,
    output logic                       rd_side
);
    localparam int IDX_W     = $clog2(EVENT_DEPTH);
    localparam int MEM_DEPTH = 2 * (1 << IDX_W);

    logic [TIME_BITS-1:0]       mem_time    [MEM_DEPTH];
    logic [ceb_pkg::ADDR_W-1:0] mem_address [MEM_DEPTH];
    logic                       mem_side    [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_time[wr_addr]    <= wr_time;
            mem_address[wr_addr] <= wr_address;
            mem_side[wr_addr]    <= wr_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_time    <= mem_time[rd_addr];
            rd_address <= mem_address[rd_addr];
            rd_side    <= mem_side[rd_addr];
        end
    end

endmodule

// ----- hdl/ceb_cmdq.sv -----
// Two-entry queue of closed-event commands between front and back.
module ceb_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ceb_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output ceb_pkg::cmd_t pop_cmd
);
    ceb_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/ceb_front.sv -----
// Front end: takes hits, tracks the window and side coincidences, fills banks.
module ceb_front #(
    parameter int EVENT_DEPTH = ceb_pkg::EVENT_DEPTH_DEF,
    parameter int MAX_REQ     = ceb_pkg::MAX_REQ_DEF,
    parameter int TIME_BITS   = ceb_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ceb_in_if.sink                       hits,
    input  ceb_pkg::cfg_t                cfg,
    output logic                         cmd_push,
    output ceb_pkg::cmd_t                cmd,
    input  logic                         cmd_ready,
    input  ceb_pkg::release_t            rel,
    output logic                         wr_en,
    output logic [$clog2(EVENT_DEPTH):0] wr_addr,
    output logic [TIME_BITS-1:0]         wr_time,
    output logic [ceb_pkg::ADDR_W-1:0]   wr_address,
    output logic                         wr_side
);
    localparam int IDX_W  = $clog2(EVENT_DEPTH);
    localparam int FILL_W = $clog2(EVENT_DEPTH + 1);
    localparam int SIDE_W = 2 * MAX_REQ;

    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_mode_reg;
    logic [TIME_BITS-1:0]       pend_time_reg;
    logic [ceb_pkg::ADDR_W-1:0] pend_addr_reg;
    logic                       pend_side_reg;

    logic                       open_reg, open_next;
    logic                       cur_bank_reg, cur_bank_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [TIME_BITS-1:0]       wstart_reg, wstart_next;
    logic [SIDE_W-1:0]          side_reg, side_next;
    logic                       ovf_reg, ovf_next;
    logic [1:0]                 busy_reg, busy_next;

    logic [TIME_BITS-1:0]       diff;
    logic                       is_flush, out_win, closing, opening, new_bank;
    logic                       can_go, fire, load;
    logic [FILL_W-1:0]          base_fill;
    logic [SIDE_W-1:0]          base_side, match_bits;
    logic                       base_ovf;
    logic [2:0]                 n_used, both;
    logic                       acc;
    logic [1:0]                 busy_set, busy_clr;

    always_comb
    begin
        is_flush = pend_mode_reg == ceb_pkg::MODE_FLUSH;
        diff     = pend_time_reg - wstart_reg;
        out_win  = diff >= TIME_BITS'(cfg.max_delta);
        closing  = open_reg && (is_flush || out_win);
        opening  = !is_flush && (closing || !open_reg);
        new_bank = cur_bank_reg ^ closing;
        can_go   = !(closing && !cmd_ready) && !(opening && busy_reg[new_bank]);
        fire     = pend_valid_reg && can_go;
        load     = hits.valid && hits.ready;

        base_fill = opening ? '0 : fill_reg;
        base_side = opening ? '0 : side_reg;
        base_ovf  = opening ? 1'b0 : ovf_reg;

        match_bits = '0;
        for (int i = 0; i < MAX_REQ; i++)
        begin
            if (pend_addr_reg[ceb_pkg::REQ_ADDR_W-1:0] == cfg.req_addr[i])
            begin
                match_bits[2*i + int'(pend_side_reg)] = 1'b1;
                if (cfg.req_addr[i] == ceb_pkg::PAD_ADDR)
                begin
                    match_bits[2*i + 1] = 1'b1;
                end
            end
        end

        // coincidence decision over the event being closed
        n_used = (cfg.req_count > 3'(MAX_REQ)) ? 3'(MAX_REQ) : cfg.req_count;
        both   = 3'd0;
        for (int i = 0; i < MAX_REQ; i++)
        begin
            if ((3'(i) < n_used) && (side_reg[2*i +: 2] == 2'b11))
            begin
                both = both + 3'd1;
            end
        end
        if (n_used == 3'd0)
        begin
            acc = 1'b1;
        end
        else if (cfg.req_mode == 3'd0)
        begin
            acc = both == n_used;
        end
        else
        begin
            acc = both >= cfg.req_mode;
        end
    end

    assign hits.ready   = !pend_valid_reg || fire;
    assign cmd_push     = fire && closing;
    assign cmd.bank     = cur_bank_reg;
    assign cmd.count    = ceb_pkg::CNT_W'(fill_reg);
    assign cmd.accepted = acc;
    assign cmd.truncated = ovf_reg;

    assign wr_en      = fire && !is_flush && (base_fill < FILL_W'(EVENT_DEPTH));
    assign wr_addr    = {new_bank, base_fill[IDX_W-1:0]};
    assign wr_time    = pend_time_reg;
    assign wr_address = pend_addr_reg;
    assign wr_side    = pend_side_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load)
        begin
            pend_valid_next = 1'b1;
        end
        else if (fire)
        begin
            pend_valid_next = 1'b0;
        end

        open_next     = open_reg;
        cur_bank_next = cur_bank_reg;
        fill_next     = fill_reg;
        wstart_next   = wstart_reg;
        side_next     = side_reg;
        ovf_next      = ovf_reg;
        busy_set      = 2'b00;
        busy_clr      = 2'b00;

        if (rel.valid)
        begin
            busy_clr[rel.bank] = 1'b1;
        end

        if (fire)
        begin
            if (closing)
            begin
                busy_set[cur_bank_reg] = 1'b1;
                cur_bank_next          = new_bank;
            end
            if (is_flush)
            begin
                if (closing)
                begin
                    open_next = 1'b0;
                    fill_next = '0;
                    side_next = '0;
                    ovf_next  = 1'b0;
                end
            end
            else
            begin
                open_next = 1'b1;
                if (opening)
                begin
                    wstart_next = pend_time_reg;
                end
                side_next = base_side | match_bits;
                if (base_fill < FILL_W'(EVENT_DEPTH))
                begin
                    fill_next = base_fill + 1'b1;
                    ovf_next  = base_ovf;
                end
                else
                begin
                    fill_next = base_fill;
                    ovf_next  = 1'b1;
                end
            end
        end

        busy_next = (busy_reg & ~busy_clr) | busy_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            cur_bank_reg   <= 1'b0;
            fill_reg       <= '0;
            wstart_reg     <= '0;
            side_reg       <= '0;
            ovf_reg        <= 1'b0;
            busy_reg       <= 2'b00;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            open_reg       <= open_next;
            cur_bank_reg   <= cur_bank_next;
            fill_reg       <= fill_next;
            wstart_reg     <= wstart_next;
            side_reg       <= side_next;
            ovf_reg        <= ovf_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_mode_reg <= hits.mode;
            pend_time_reg <= hits.hit_time;
            pend_addr_reg <= hits.hit_address;
            pend_side_reg <= hits.hit_side;
        end
    end

    // the bank being filled is never one still held by the drain side
    a_open_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> !busy_reg[cur_bank_reg])
        else $error("open event sits in a busy bank");

    a_open_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (fill_reg != '0))
        else $error("open event holds no hit");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd_ready && !busy_reg[cur_bank_reg]))
        else $error("close command pushed without room");

endmodule

// ----- hdl/ceb_back.sv -----
// Back end: drains a closed bank as event words through a two-stage read pipeline.
module ceb_back #(
    parameter int EVENT_DEPTH = ceb_pkg::EVENT_DEPTH_DEF,
    parameter int TIME_BITS   = ceb_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  ceb_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output ceb_pkg::release_t            rel,
    output logic                         rd_en,
    output logic [$clog2(EVENT_DEPTH):0] rd_addr,
    input  logic [TIME_BITS-1:0]         rd_time,
    input  logic [ceb_pkg::ADDR_W-1:0]   rd_address,
    input  logic                         rd_side,
    ceb_out_if.source                    events
);
    localparam int IDX_W = $clog2(EVENT_DEPTH);

    logic                        act_reg, act_next;
    logic                        bank_reg;
    logic [ceb_pkg::CNT_W-1:0]   count_reg;
    logic [ceb_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                        acc_reg, trunc_reg;

    logic                        a_valid_reg, a_valid_next;
    logic                        a_last_reg, a_acc_reg, a_trunc_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]        out_time_reg;
    logic [ceb_pkg::ADDR_W-1:0]  out_address_reg;
    logic                        out_side_reg, out_acc_reg, out_last_reg, out_trunc_reg;

    logic                        b_load, a_load, issue, issue_last;

    always_comb
    begin
        b_load     = !out_valid_reg || events.ready;
        a_load     = !a_valid_reg || b_load;
        issue      = act_reg && a_load;
        issue_last = (idx_reg + 1'b1) == count_reg;
        cmd_pop    = !act_reg && cmd_valid;

        act_next = act_reg;
        idx_next = idx_reg;
        if (cmd_pop)
        begin
            act_next = 1'b1;
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
            if (issue_last)
            begin
                act_next = 1'b0;
            end
        end

        a_valid_next   = a_load ? issue : a_valid_reg;
        out_valid_next = b_load ? a_valid_reg : out_valid_reg;
    end

    assign rd_en     = issue;
    assign rd_addr   = {bank_reg, idx_reg[IDX_W-1:0]};
    assign rel.valid = issue && issue_last;
    assign rel.bank  = bank_reg;

    assign events.valid         = out_valid_reg;
    assign events.out_time      = out_time_reg;
    assign events.out_address   = out_address_reg;
    assign events.out_side      = out_side_reg;
    assign events.accepted      = out_acc_reg;
    assign events.last_of_event = out_last_reg;
    assign events.truncated     = out_trunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            idx_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            bank_reg  <= cmd.bank;
            count_reg <= cmd.count;
            acc_reg   <= cmd.accepted;
            trunc_reg <= cmd.truncated;
        end
        if (issue)
        begin
            a_last_reg  <= issue_last;
            a_acc_reg   <= acc_reg;
            a_trunc_reg <= trunc_reg;
        end
        if (b_load && a_valid_reg)
        begin
            out_time_reg    <= rd_time;
            out_address_reg <= rd_address;
            out_side_reg    <= rd_side;
            out_acc_reg     <= a_acc_reg;
            out_last_reg    <= a_last_reg;
            out_trunc_reg   <= a_trunc_reg;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (idx_reg < count_reg))
        else $error("drain index past event size");

    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |=> !act_reg)
        else $error("bank released while drain still active");

endmodule

// ----- tb/coincidence_event_builder_tb.sv -----
// Self-checking testbench for the coincidence event builder: hit stream in, event words out.
module coincidence_event_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ceb_pkg::*;

    localparam int TB_TIME_W   = TIME_BITS_DEF;
    localparam int TB_DEPTH    = EVENT_DEPTH_DEF;
    localparam int TB_SLOTS    = MAX_REQ_DEF;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAUSE = 24;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] ADDR_REGS [TB_SLOTS] =
        '{CFG_REQ_ADDR_0, CFG_REQ_ADDR_1, CFG_REQ_ADDR_2, CFG_REQ_ADDR_3};
    localparam logic [TB_TIME_W-1:0] TIME_TOP = {TB_TIME_W{1'b1}};

    typedef struct packed {
        logic                 mode;
        logic [TB_TIME_W-1:0] t;
        logic [ADDR_W-1:0]    addr;
        logic                 side;
    } hit_item_t;

    typedef struct packed {
        logic [TB_TIME_W-1:0] t;
        logic [ADDR_W-1:0]    addr;
        logic                 side;
        logic                 accepted;
        logic                 last;
        logic                 truncated;
    } event_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ceb_in_if  #(.TIME_BITS(TB_TIME_W)) hits_ch ();
    ceb_out_if #(.TIME_BITS(TB_TIME_W)) events_ch ();

    coincidence_event_builder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hits      (hits_ch),
        .events    (events_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // configuration copy
    logic [2:0]            m_req_count = 3'd0;
    logic [REQ_ADDR_W-1:0] m_req_addr [TB_SLOTS] = '{default: '0};
    logic [2:0]            m_req_mode = 3'd0;
    logic [DELTA_W-1:0]    m_max_delta = MAX_DELTA_RST;

    // window state
    logic [TB_TIME_W-1:0] buf_time [TB_DEPTH];
    logic [ADDR_W-1:0]    buf_addr [TB_DEPTH];
    logic                 buf_side [TB_DEPTH];
    int unsigned          buf_fill = 0;
    logic [TB_TIME_W-1:0] win_start = '0;
    logic [2*TB_SLOTS-1:0] sides_hit = '0;
    bit                   win_open = 1'b0;
    bit                   win_overflow = 1'b0;

    hit_item_t   hit_q [$];
    event_word_t expected_words [$];
    hit_item_t   next_hit;
    event_word_t want;
    logic [TB_TIME_W-1:0] cur_time;

    int errors = 0;
    logic steady = 1'b0;
    logic hold_arm = 1'b0;
    logic hold_taken;
    int   hold_left;

    initial
    begin
        hits_ch.valid       = 1'b0;
        hits_ch.mode        = MODE_HIT;
        hits_ch.hit_time    = '0;
        hits_ch.hit_address = '0;
        hits_ch.hit_side    = 1'b0;
        events_ch.ready     = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        hold_taken          = 1'b0;
        hold_left           = 0;
    end

    function automatic bit coincidence_met();
        int unsigned slots;
        int unsigned both;
        slots = (m_req_count > TB_SLOTS) ? TB_SLOTS : m_req_count;
        both = 0;
        if (slots == 0)
            return 1'b1;
        for (int i = 0; i < slots; i++)
            if (sides_hit[2*i +: 2] == 2'b11)
                both++;
        if (m_req_mode == 0)
            return both == slots;
        return both >= m_req_mode;
    endfunction

    function automatic void close_window();
        bit acc;
        event_word_t w;
        acc = coincidence_met();
        for (int k = 0; k < buf_fill; k++)
        begin
            w.t         = buf_time[k];
            w.addr      = buf_addr[k];
            w.side      = buf_side[k];
            w.accepted  = acc;
            w.last      = (k + 1 == buf_fill);
            w.truncated = win_overflow;
            expected_words.push_back(w);
        end
        win_open     = 1'b0;
        buf_fill     = 0;
        sides_hit    = '0;
        win_overflow = 1'b0;
    endfunction

    function automatic void track_hit(logic mode, logic [TB_TIME_W-1:0] t,
                                      logic [ADDR_W-1:0] addr, logic side);
        logic [TB_TIME_W-1:0] diff;
        diff = t - win_start;
        if (mode == MODE_FLUSH)
        begin
            if (win_open)
                close_window();
            return;
        end
        if (win_open && diff >= TB_TIME_W'(m_max_delta))
            close_window();
        if (!win_open)
        begin
            win_open     = 1'b1;
            win_start    = t;
            buf_fill     = 0;
            sides_hit    = '0;
            win_overflow = 1'b0;
        end
        if (buf_fill < TB_DEPTH)
        begin
            buf_time[buf_fill] = t;
            buf_addr[buf_fill] = addr;
            buf_side[buf_fill] = side;
            buf_fill++;
        end
        else
            win_overflow = 1'b1;
        for (int i = 0; i < TB_SLOTS; i++)
            if (addr[REQ_ADDR_W-1:0] == m_req_addr[i])
            begin
                sides_hit[2*i + side] = 1'b1;
                if (m_req_addr[i] == PAD_ADDR)
                    sides_hit[2*i + 1] = 1'b1;
            end
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // hit driver
    always @(posedge clk)
    begin
        if (!rst_n)
            hits_ch.valid <= 1'b0;
        else if (!hits_ch.valid || hits_ch.ready)
        begin
            if (hit_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_hit = hit_q.pop_front();
                hits_ch.mode        <= next_hit.mode;
                hits_ch.hit_time    <= next_hit.t;
                hits_ch.hit_address <= next_hit.addr;
                hits_ch.hit_side    <= next_hit.side;
                hits_ch.valid       <= 1'b1;
            end
            else
                hits_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n && hits_ch.valid && hits_ch.ready)
            track_hit(hits_ch.mode, hits_ch.hit_time, hits_ch.hit_address, hits_ch.hit_side);

    // event word receiver, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            events_ch.ready <= 1'b0;
        else if (hold_arm && !hold_taken)
        begin
            hold_taken      <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            events_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            events_ch.ready <= 1'b0;
        end
        else
            events_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
        if (rst_n && events_ch.valid && events_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected event word: time %0h address %0h",
                       events_ch.out_time, events_ch.out_address);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("out_time", want.t, events_ch.out_time);
                check_field("out_address", want.addr, events_ch.out_address);
                check_field("out_side", want.side, events_ch.out_side);
                check_field("accepted", want.accepted, events_ch.accepted);
                check_field("last_of_event", want.last, events_ch.last_of_event);
                check_field("truncated", want.truncated, events_ch.truncated);
            end
        end

    function automatic logic [TB_TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TB_TIME_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int unsigned r;
        int unsigned slots;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        a = $urandom;
        slots = (m_req_count == 0 || m_req_count > TB_SLOTS) ? TB_SLOTS : m_req_count;
        if (r < 65)
            a[REQ_ADDR_W-1:0] = m_req_addr[$urandom_range(0, slots - 1)];
        else if (r < 75)
            a[REQ_ADDR_W-1:0] = PAD_ADDR;
        return a;
    endfunction

    function automatic void push_hit(logic [TB_TIME_W-1:0] t, logic [ADDR_W-1:0] addr,
                                     logic side);
        hit_q.push_back(hit_item_t'{mode: MODE_HIT, t: t, addr: addr, side: side});
    endfunction

    function automatic void push_flush();
        hit_q.push_back(hit_item_t'{mode: MODE_FLUSH, t: rand_time(), addr: $urandom,
                                    side: 1'($urandom_range(0, 1))});
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_REQ_COUNT:  m_req_count = data[2:0];
            CFG_REQ_ADDR_0,
            CFG_REQ_ADDR_1,
            CFG_REQ_ADDR_2,
            CFG_REQ_ADDR_3: m_req_addr[idx - CFG_REQ_ADDR_0] = data[REQ_ADDR_W-1:0];
            CFG_REQ_MODE:   m_req_mode = data[2:0];
            CFG_MAX_DELTA:  m_max_delta = data[DELTA_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all hits taken and all words out, then let the pipeline go quiet
    task automatic settle();
        while (hit_q.size() != 0 || hits_ch.valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic random_config();
        int unsigned r;
        int unsigned slots;
        r = $urandom_range(0, 99);
        write_reg(CFG_REQ_COUNT,
                  CFG_DATA_W'((r < 10) ? $urandom_range(5, 7) : $urandom_range(0, 4)));
        for (int i = 0; i < TB_SLOTS; i++)
            write_reg(ADDR_REGS[i], CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
        slots = (m_req_count > TB_SLOTS) ? TB_SLOTS : m_req_count;
        r = $urandom_range(0, 99);
        write_reg(CFG_REQ_MODE,
                  CFG_DATA_W'((r < 15) ? $urandom_range(0, 7) : $urandom_range(0, slots)));
        r = $urandom_range(0, 99);
        if (r < 10)
            write_reg(CFG_MAX_DELTA, 0);
        else if (r < 20)
            write_reg(CFG_MAX_DELTA, 16'hFFFF);
        else
            write_reg(CFG_MAX_DELTA, CFG_DATA_W'($urandom_range(1, 3000)));
    endtask

    // well-formed events with random content, plus flushes and out-of-order noise
    task automatic gen_events(int unsigned n_events, int unsigned max_hits);
        int unsigned hit_count;
        int unsigned r;
        logic [TB_TIME_W-1:0] ev_start;
        logic [TB_TIME_W-1:0] step_max;
        for (int e = 0; e < n_events; e++)
        begin
            r = $urandom_range(0, 99);
            hit_count = (r < 15) ? $urandom_range(1, max_hits) : $urandom_range(1, 5);
            step_max = m_max_delta / hit_count;
            ev_start = cur_time;
            for (int h = 0; h < hit_count; h++)
            begin
                push_hit(cur_time, pick_addr(), 1'($urandom_range(0, 1)));
                cur_time = cur_time + $urandom_range(0, step_max);
            end
            r = $urandom_range(0, 99);
            if (r < 15)
                push_flush();
            else if (r < 20)
            begin
                push_flush();
                push_flush();
            end
            else if (r < 27)
                push_hit(cur_time - $urandom_range(1, 5000), $urandom,
                         1'($urandom_range(0, 1)));
            else if (r < 32)
                push_hit(ev_start + $urandom_range(0, m_max_delta), pick_addr(),
                         1'($urandom_range(0, 1)));
            cur_time = ev_start + m_max_delta + $urandom_range(0, 2000);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no required addresses, window 500
        push_hit(0, 32'h0000_0000, 1'b0);
        push_hit(499, 32'hFFFF_FFFF, 1'b1);
        push_hit(500, 32'h8000_0001, 1'b0);
        push_flush();
        push_flush();
        push_hit(TIME_TOP, 32'h1234_5678, 1'b1);
        push_hit(5, 32'hA5A5_5A5A, 1'b0);
        push_hit(48'h8000_0000_0000, 32'h5A5A_A5A5, 1'b1);
        push_hit(48'h7FFF_FFFF_FFFF, 32'h0F0F_F0F0, 1'b0);
        push_flush();
        settle();

        // zero window: every hit is its own event
        write_reg(CFG_REQ_COUNT, 2);
        write_reg(CFG_REQ_ADDR_0, PAD_ADDR);
        write_reg(CFG_REQ_ADDR_1, 17'h1FFFF);
        write_reg(CFG_REQ_MODE, 0);
        write_reg(CFG_MAX_DELTA, 0);
        push_hit(100, {15'h7FFF, PAD_ADDR}, 1'b0);
        push_hit(100, {15'h0000, 17'h1FFFF}, 1'b1);
        settle();

        // widest window, count saturates, at least two slots; event stays open across writes
        write_reg(CFG_MAX_DELTA, 16'hFFFF);
        write_reg(CFG_REQ_ADDR_2, 17'h00000);
        write_reg(CFG_REQ_ADDR_3, 17'h0ABCD);
        write_reg(CFG_REQ_MODE, 2);
        write_reg(CFG_REQ_COUNT, 17'h1FFFF);
        write_reg(CFG_UNUSED, 17'h15A5A);
        push_hit(101, {15'h1234, 17'h1FFFF}, 1'b0);
        push_hit(65634, 32'h0000_0000, 1'b1);
        push_hit(65634, {15'h0000, PAD_ADDR}, 1'b0);
        push_hit(65635, 32'h0000_0000, 1'b0);
        settle();

        write_reg(CFG_REQ_MODE, 7);
        push_hit(65700, {15'h4321, 17'h0ABCD}, 1'b1);
        push_hit(65701, 32'hFFFE_0000, 1'b1);
        push_flush();
        settle();
        write_reg(CFG_REQ_COUNT, 0);
        push_hit(70000, {15'h2AAA, 17'h0ABCD}, 1'b0);
        push_flush();
        settle();

        // random settings and event streams
        cur_time = 1000;
        for (int p = 0; p < 4; p++)
        begin
            random_config();
            if (p % 2 == 1)
                cur_time = rand_time();
            if (p == 2)
                steady <= 1'b1;
            gen_events(2, 6);
            if ($urandom_range(0, 1))
                push_flush();
            settle();
            steady <= 1'b0;
        end

        // buffer overflow; late hits still complete the coincidence
        write_reg(CFG_REQ_COUNT, 1);
        write_reg(CFG_REQ_ADDR_0, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
        write_reg(CFG_REQ_MODE, 0);
        write_reg(CFG_MAX_DELTA, 16'hFFFF);
        steady <= 1'b1;
        for (int h = 0; h < TB_DEPTH + 3; h++)
        begin
            if (h >= TB_DEPTH + 1)
                push_hit(cur_time, {15'($urandom), m_req_addr[0]}, h[0]);
            else
                push_hit(cur_time, $urandom, 1'($urandom_range(0, 1)));
            cur_time = cur_time + $urandom_range(0, 50);
        end
        push_flush();
        settle();
        steady <= 1'b0;

        // receiver holds off while events keep coming
        write_reg(CFG_REQ_COUNT, 0);
        write_reg(CFG_MAX_DELTA, 1000);
        @(posedge clk);
        hold_arm <= 1'b1;
        for (int e = 0; e < 3; e++)
        begin
            for (int h = 0; h < 5; h++)
            begin
                push_hit(cur_time, $urandom, 1'($urandom_range(0, 1)));
                cur_time = cur_time + $urandom_range(0, 20);
            end
            cur_time = cur_time + 1000;
        end
        push_flush();
        settle();

        if (errors == 0)
            $display("coincidence_event_builder: match");
        else
            $display("coincidence_event_builder: mismatch");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("coincidence_event_builder: mismatch");
        $finish;
    end

endmodule
